[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define GAPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is followed by an expected condition in the next cycle.
`define GAPS_ASSERT_NEXT(label, cond, expct, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) else $error(msg);

`endif

[rtl/gaps_pkg.sv]
package gaps_pkg;

  // Default sizes of the map and of the heuristic fraction.
  localparam int unsigned GRID_W_DEF    = 8;
  localparam int unsigned GRID_H_DEF    = 8;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int unsigned CRD_W = 3;
  localparam int unsigned G_W   = 7;
  localparam int unsigned F_W   = 16;
  localparam int unsigned ORD_W = 8;

  // Request actions.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_AUTO   = 2'd2;

  // Heuristic modes.
  localparam logic [1:0] MODE_MANH = 2'd0;
  localparam logic [1:0] MODE_EUCL = 2'd1;
  localparam logic [1:0] MODE_CHEB = 2'd2;
  localparam logic [1:0] MODE_OCT  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Neighbor steps: up, right, down, left, then the diagonals.
  localparam logic signed [1:0] STEP_DX [8] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                               -2'sd1, 2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] STEP_DY [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                               -2'sd1, 2'sd1, -2'sd1, 2'sd1};

  // Request to the heuristic unit.
  typedef struct packed {
    logic             start;
    logic [1:0]       mode;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] gx;
    logic [CRD_W-1:0] gy;
  } heur_req_t;

  // Answer of the heuristic unit.
  typedef struct packed {
    logic           done;
    logic [F_W-1:0] value;
  } heur_rsp_t;

endpackage

[rtl/gaps_heur.sv]
module gaps_heur #(
  parameter int unsigned FRAC_BITS = gaps_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gaps_pkg::heur_req_t req,
  output gaps_pkg::heur_rsp_t rsp
);
  import gaps_pkg::*;

  localparam int unsigned RW    = FRAC_BITS + 4;
  localparam int unsigned NP    = FRAC_BITS + 4;
  localparam int unsigned CNT_W = $clog2(NP + 1);
  localparam int unsigned OCT_K = ((150 << FRAC_BITS) + 128) >> 8;

  logic [CRD_W-1:0] dx;
  logic [CRD_W-1:0] dy;
  logic [CRD_W-1:0] mn;
  logic [CRD_W-1:0] mx;
  logic [3:0]       sum;
  logic [7:0]       sq;
  logic [RW-1:0]    h_man;
  logic [RW-1:0]    h_cheb;
  logic [RW-1:0]    h_oct;
  logic [RW-1:0]    h_sel;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       sv_r;
  logic [RW-1:0]    root_r;
  logic [RW+1:0]    rem_r;
  logic [F_W-1:0]   val_r;

  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;
  logic [RW-1:0]    root_nxt;
  logic [RW+1:0]    rem_nxt;

  // Distance terms of the cell to the goal.
  always_comb begin
    dx     = (req.x > req.gx) ? req.x - req.gx : req.gx - req.x;
    dy     = (req.y > req.gy) ? req.y - req.gy : req.gy - req.y;
    mn     = (dx < dy) ? dx : dy;
    mx     = (dx < dy) ? dy : dx;
    sum    = {1'b0, dx} + {1'b0, dy};
    sq     = ({5'd0, dx} * {5'd0, dx}) + ({5'd0, dy} * {5'd0, dy});
    h_man  = RW'({sum, FRAC_BITS'(0)});
    h_cheb = RW'({mx, FRAC_BITS'(0)});
    h_oct  = h_man - RW'(RW'(mn) * RW'(OCT_K));
    case (req.mode)
      MODE_MANH: h_sel = h_man;
      MODE_CHEB: h_sel = h_cheb;
      default:   h_sel = h_oct;
    endcase
  end

  // One root bit per cycle of the square root.
  always_comb begin
    rem_sh = {rem_r[RW-1:0], sv_r[7:6]};
    trial  = {root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.mode == MODE_EUCL) begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(NP);
          sv_r   <= sq;
          root_r <= '0;
          rem_r  <= '0;
        end else begin
          done_r <= 1'b1;
          val_r  <= F_W'(h_sel);
        end
      end else if (busy_r) begin
        sv_r   <= {sv_r[5:0], 2'b00};
        root_r <= root_nxt;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          val_r  <= F_W'(root_nxt);
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = val_r;

endmodule

[rtl/grid_astar_path_search_unit.sv]
// Grid A* path search.
// Requests arrive on the in_ channel: a load writes one obstacle bit; a
// search, or an auto request from the first free cell of the bottom row
// to the first free cell of the top row, runs A* over the active map area
// and then delivers the path from start to goal on the out_ channel, one
// cell per result with last on the final one, or a single not-found result.
// The cfg_ channel writes the heuristic mode and the active grid size; it is
// always ready, and it is to be written only while no search is running;
// the block itself does not enforce this.
// A search expands one cell at a time and checks its neighbors (4 in
// manhattan mode, else 8). The open-set scan reads the node memory one
// entry per cycle. The path walk writes each cell to the path buffer and
// reads its parent, then the path is read back from the buffer and sent.
// Reset clears the map to all free, the mode to octile and the size to 8 by
// 8, clamped to the map. A stalled receiver holds the result register and
// the search sequencer waits; a new request is taken once the last result
// is loaded.
`include "assert_macros.svh"

module grid_astar_path_search_unit #(
  parameter int unsigned GRID_W    = gaps_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H    = gaps_pkg::GRID_H_DEF,
  parameter int unsigned FRAC_BITS = gaps_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [3:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_action,
  input  logic [gaps_pkg::CRD_W-1:0] in_cell_x,
  input  logic [gaps_pkg::CRD_W-1:0] in_cell_y,
  input  logic                       in_blocked,
  input  logic [gaps_pkg::CRD_W-1:0] in_start_x,
  input  logic [gaps_pkg::CRD_W-1:0] in_start_y,
  input  logic [gaps_pkg::CRD_W-1:0] in_goal_x,
  input  logic [gaps_pkg::CRD_W-1:0] in_goal_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gaps_pkg::CRD_W-1:0] out_path_x,
  output logic [gaps_pkg::CRD_W-1:0] out_path_y,
  output logic                       out_found,
  output logic                       out_last
);
  import gaps_pkg::*;

  localparam int unsigned NCELLS = GRID_W * GRID_H;
  localparam int unsigned CW     = $clog2(NCELLS);
  localparam int unsigned SW     = ((G_W + FRAC_BITS > F_W) ? G_W + FRAC_BITS : F_W) + 1;

  typedef struct packed {
    logic [G_W-1:0]   g;
    logic [F_W-1:0]   f;
    logic [CRD_W-1:0] par_x;
    logic [CRD_W-1:0] par_y;
    logic [ORD_W-1:0] ord;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT_H, S_INIT_W, S_SCAN, S_PICK, S_NBR, S_NCHK, S_NHW,
    S_PWR, S_PRD, S_ERD, S_EOUT, S_NF
  } state_t;

  function automatic logic [CW-1:0] cidx(input logic [CRD_W-1:0] x,
                                          input logic [CRD_W-1:0] y);
    cidx = CW'(CW'(y) * CW'(GRID_W) + CW'(x));
  endfunction

  state_t state_r;

  // Configuration registers.
  logic [1:0] mode_r;
  logic [3:0] gw_r;
  logic [3:0] gh_r;
  logic [3:0] wc;
  logic [3:0] hc;
  logic [CRD_W-1:0] hc_m1;

  // Per-cell flags.
  logic [NCELLS-1:0] obst_r;
  logic [NCELLS-1:0] open_r;
  logic [NCELLS-1:0] closed_r;

  // Search registers.
  logic [CRD_W-1:0] sx_r, sy_r, gx_r, gy_r;
  logic [CRD_W-1:0] cur_x_r, cur_y_r;
  logic [G_W-1:0]   cur_g_r;
  logic [ORD_W-1:0] ord_r;
  logic [ORD_W-1:0] wr_ord_r;
  logic [3:0]       dir_r;

  // Open-set scan registers.
  logic [CRD_W-1:0] scan_x_r, scan_y_r;
  logic             scan_iss_r;
  logic             sv_r;
  logic [CRD_W-1:0] pv_x_r, pv_y_r;
  logic             have_r;
  logic [CRD_W-1:0] best_x_r, best_y_r;
  logic [G_W-1:0]   best_g_r;
  logic [F_W-1:0]   best_f_r;
  logic [ORD_W-1:0] best_ord_r;

  // Path walk registers.
  logic [CRD_W-1:0] c_x_r, c_y_r;
  logic [CW:0]      pn_r;
  logic [CW:0]      pn_nxt;
  logic [CW-1:0]    ek_r;

  // Result register.
  logic             out_valid_r;
  logic [CRD_W-1:0] out_x_r, out_y_r;
  logic             out_found_r, out_last_r;
  logic             out_free;
  logic             out_load;
  logic             search_take;

  // Memories.
  node_t                node_mem [NCELLS];
  node_t                node_q;
  logic                 node_we;
  logic [CW-1:0]        node_waddr;
  node_t                node_wdata;
  logic [CW-1:0]        node_raddr;
  logic [2*CRD_W-1:0]   pbuf [NCELLS];
  logic [2*CRD_W-1:0]   pb_q;

  // Endpoint search and neighbor terms.
  logic             bot_found, top_found;
  logic [CRD_W-1:0] bot_x, top_x;
  logic [2:0]       dsel;
  logic signed [4:0] nx_s, ny_s;
  logic [CRD_W-1:0] nx, ny;
  logic [CW-1:0]    nidx;
  logic             nbr_ok;
  logic [3:0]       nd;
  logic [G_W-1:0]   tg;
  logic             upd;
  logic             scan_last;
  logic             better;
  logic [CW-1:0]    pv_idx;

  heur_req_t        hreq;
  heur_rsp_t        hrsp;
  logic [G_W-1:0]   fg;
  logic [SW-1:0]    fsum;
  logic [F_W-1:0]   fval;

  // Active area, with out-of-range sizes clamped.
  always_comb begin
    if (gw_r == 4'd0) wc = 4'd1;
    else if (gw_r > 4'(GRID_W)) wc = 4'(GRID_W);
    else wc = gw_r;
    if (gh_r == 4'd0) hc = 4'd1;
    else if (gh_r > 4'(GRID_H)) hc = 4'(GRID_H);
    else hc = gh_r;
    hc_m1 = CRD_W'(hc - 4'd1);
  end

  // First free cell of the bottom and top rows.
  always_comb begin
    bot_found = 1'b0;
    top_found = 1'b0;
    bot_x     = '0;
    top_x     = '0;
    for (int i = 0; i < GRID_W; i++) begin
      if (!bot_found && 4'(i) < wc && !obst_r[cidx(CRD_W'(i), hc_m1)]) begin
        bot_found = 1'b1;
        bot_x     = CRD_W'(i);
      end
      if (!top_found && 4'(i) < wc && !obst_r[cidx(CRD_W'(i), CRD_W'(0))]) begin
        top_found = 1'b1;
        top_x     = CRD_W'(i);
      end
    end
  end

  // Current neighbor and its admission test.
  always_comb begin
    dsel   = dir_r[2:0];
    nx_s   = $signed({2'b00, cur_x_r}) + $signed({{3{STEP_DX[dsel][1]}}, STEP_DX[dsel]});
    ny_s   = $signed({2'b00, cur_y_r}) + $signed({{3{STEP_DY[dsel][1]}}, STEP_DY[dsel]});
    nx     = nx_s[CRD_W-1:0];
    ny     = ny_s[CRD_W-1:0];
    nidx   = cidx(nx, ny);
    nbr_ok = !nx_s[4] && !ny_s[4] && (nx_s[3:0] < wc) && (ny_s[3:0] < hc) &&
             !obst_r[nidx] && !closed_r[nidx];
    nd     = (mode_r == MODE_MANH) ? 4'd4 : 4'd8;
    tg     = cur_g_r + 1'b1;
    upd    = !open_r[nidx] || (tg < node_q.g);
  end

  // Scan compare against the best open entry so far.
  always_comb begin
    pv_idx    = cidx(pv_x_r, pv_y_r);
    scan_last = (scan_x_r == CRD_W'(GRID_W - 1)) && (scan_y_r == CRD_W'(GRID_H - 1));
    better    = !have_r || (node_q.f < best_f_r) ||
                ((node_q.f == best_f_r) && (node_q.ord < best_ord_r));
  end

  // Heuristic request and f value.
  always_comb begin
    hreq.start = (state_r == S_INIT_H) || ((state_r == S_NCHK) && upd);
    hreq.mode  = mode_r;
    hreq.x     = (state_r == S_INIT_H) ? sx_r : nx;
    hreq.y     = (state_r == S_INIT_H) ? sy_r : ny;
    hreq.gx    = gx_r;
    hreq.gy    = gy_r;
    fg         = (state_r == S_INIT_W) ? '0 : tg;
    fsum       = SW'({fg, FRAC_BITS'(0)}) + SW'(hrsp.value);
    fval       = (fsum > SW'(16'hFFFF)) ? 16'hFFFF : fsum[F_W-1:0];
  end

  gaps_heur #(
    .FRAC_BITS(FRAC_BITS)
  ) u_heur (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (hreq),
    .rsp  (hrsp)
  );

  // Node memory access.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = nidx;
    node_wdata = '{g: tg, f: fval, par_x: cur_x_r, par_y: cur_y_r, ord: wr_ord_r};
    if (state_r == S_INIT_W && hrsp.done) begin
      node_we    = 1'b1;
      node_waddr = cidx(sx_r, sy_r);
      node_wdata = '{g: '0, f: fval, par_x: sx_r, par_y: sy_r, ord: '0};
    end else if (state_r == S_NHW && hrsp.done) begin
      node_we = 1'b1;
    end
    case (state_r)
      S_SCAN:                node_raddr = cidx(scan_x_r, scan_y_r);
      S_NBR, S_NCHK, S_NHW:  node_raddr = nidx;
      S_PWR, S_PRD:          node_raddr = cidx(c_x_r, c_y_r);
      default:               node_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  // Path buffer memory.
  always_ff @(posedge clk) begin
    if (state_r == S_PWR) begin
      pbuf[pn_r[CW-1:0]] <= {c_y_r, c_x_r};
    end
    pb_q <= pbuf[ek_r];
  end

  assign pn_nxt      = pn_r + 1'b1;
  assign out_free    = !out_valid_r || out_ready;
  assign out_load    = out_free && (state_r == S_EOUT || state_r == S_NF);
  assign search_take = in_valid && in_ready &&
                       (in_action == ACT_SEARCH || in_action == ACT_AUTO);

  // Sequencer, flags and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_OCT;
      gw_r        <= 4'd8;
      gh_r        <= 4'd8;
      obst_r      <= '0;
      open_r      <= '0;
      closed_r    <= '0;
      out_valid_r <= 1'b0;
      scan_iss_r  <= 1'b0;
      sv_r        <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE:   mode_r <= cfg_data[1:0];
          REG_WIDTH:  gw_r   <= cfg_data;
          REG_HEIGHT: gh_r   <= cfg_data;
          default:    ;
        endcase
      end

      // The result register empties unless a new result is loaded in its place.
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_action)
              ACT_LOAD: begin
                if (32'(in_cell_x) < GRID_W && 32'(in_cell_y) < GRID_H) begin
                  obst_r[cidx(in_cell_x, in_cell_y)] <= in_blocked;
                end
              end
              ACT_SEARCH: begin
                sx_r <= in_start_x;
                sy_r <= in_start_y;
                gx_r <= in_goal_x;
                gy_r <= in_goal_y;
                if ({1'b0, in_start_x} >= wc || {1'b0, in_start_y} >= hc ||
                    {1'b0, in_goal_x} >= wc || {1'b0, in_goal_y} >= hc) begin
                  state_r <= S_NF;
                end else begin
                  open_r   <= '0;
                  closed_r <= '0;
                  state_r  <= S_INIT_H;
                end
              end
              ACT_AUTO: begin
                sx_r <= bot_x;
                sy_r <= hc_m1;
                gx_r <= top_x;
                gy_r <= '0;
                if (!bot_found || !top_found) begin
                  state_r <= S_NF;
                end else begin
                  open_r   <= '0;
                  closed_r <= '0;
                  state_r  <= S_INIT_H;
                end
              end
              default: ;
            endcase
          end
        end

        S_INIT_H: begin
          ord_r   <= ORD_W'(1);
          state_r <= S_INIT_W;
        end

        S_INIT_W: begin
          if (hrsp.done) begin
            open_r[cidx(sx_r, sy_r)] <= 1'b1;
            scan_x_r   <= '0;
            scan_y_r   <= '0;
            scan_iss_r <= 1'b1;
            sv_r       <= 1'b0;
            have_r     <= 1'b0;
            state_r    <= S_SCAN;
          end
        end

        // Walk the node memory for the lowest f among open cells.
        S_SCAN: begin
          sv_r   <= scan_iss_r;
          pv_x_r <= scan_x_r;
          pv_y_r <= scan_y_r;
          if (scan_iss_r) begin
            if (scan_last) begin
              scan_iss_r <= 1'b0;
            end else if (scan_x_r == CRD_W'(GRID_W - 1)) begin
              scan_x_r <= '0;
              scan_y_r <= scan_y_r + 1'b1;
            end else begin
              scan_x_r <= scan_x_r + 1'b1;
            end
          end
          if (sv_r && open_r[pv_idx] && better) begin
            have_r     <= 1'b1;
            best_x_r   <= pv_x_r;
            best_y_r   <= pv_y_r;
            best_g_r   <= node_q.g;
            best_f_r   <= node_q.f;
            best_ord_r <= node_q.ord;
          end
          if (!scan_iss_r && !sv_r) begin
            state_r <= S_PICK;
          end
        end

        S_PICK: begin
          if (!have_r) begin
            state_r <= S_NF;
          end else begin
            open_r[cidx(best_x_r, best_y_r)] <= 1'b0;
            if (best_x_r == gx_r && best_y_r == gy_r) begin
              c_x_r   <= best_x_r;
              c_y_r   <= best_y_r;
              pn_r    <= '0;
              state_r <= S_PWR;
            end else begin
              closed_r[cidx(best_x_r, best_y_r)] <= 1'b1;
              cur_x_r <= best_x_r;
              cur_y_r <= best_y_r;
              cur_g_r <= best_g_r;
              dir_r   <= '0;
              state_r <= S_NBR;
            end
          end
        end

        // Step through the neighbors of the expanded cell.
        S_NBR: begin
          if (dir_r == nd) begin
            scan_x_r   <= '0;
            scan_y_r   <= '0;
            scan_iss_r <= 1'b1;
            sv_r       <= 1'b0;
            have_r     <= 1'b0;
            state_r    <= S_SCAN;
          end else if (nbr_ok) begin
            state_r <= S_NCHK;
          end else begin
            dir_r <= dir_r + 1'b1;
          end
        end

        S_NCHK: begin
          if (!open_r[nidx]) begin
            open_r[nidx] <= 1'b1;
            wr_ord_r     <= ord_r;
            ord_r        <= ord_r + 1'b1;
            state_r      <= S_NHW;
          end else if (upd) begin
            wr_ord_r <= node_q.ord;
            state_r  <= S_NHW;
          end else begin
            dir_r   <= dir_r + 1'b1;
            state_r <= S_NBR;
          end
        end

        S_NHW: begin
          if (hrsp.done) begin
            dir_r   <= dir_r + 1'b1;
            state_r <= S_NBR;
          end
        end

        // Follow parents from the goal back to the start.
        S_PWR: begin
          pn_r <= pn_nxt;
          if ((c_x_r == sx_r && c_y_r == sy_r) || pn_nxt == (CW+1)'(NCELLS)) begin
            ek_r    <= pn_r[CW-1:0];
            state_r <= S_ERD;
          end else begin
            state_r <= S_PRD;
          end
        end

        S_PRD: begin
          c_x_r   <= node_q.par_x;
          c_y_r   <= node_q.par_y;
          state_r <= S_PWR;
        end

        S_ERD: begin
          state_r <= S_EOUT;
        end

        // Emit the path from start to goal.
        S_EOUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= pb_q[CRD_W-1:0];
            out_y_r     <= pb_q[2*CRD_W-1:CRD_W];
            out_found_r <= 1'b1;
            out_last_r  <= (ek_r == '0);
            if (ek_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              ek_r    <= ek_r - 1'b1;
              state_r <= S_ERD;
            end
          end
        end

        S_NF: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_found_r <= 1'b0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_path_x = out_x_r;
  assign out_path_y = out_y_r;
  assign out_found  = out_found_r;
  assign out_last   = out_last_r;

  // A search request blocks further requests until its results are loaded.
  `GAPS_ASSERT_NEXT(a_busy_after_search, search_take, !in_ready, "request taken during a search")
  // The node memory is not written while the open set is being scanned.
  `GAPS_ASSERT(a_no_write_in_scan, (state_r == S_SCAN) |-> !node_we, "node write during scan")
  // A not-found result is always the final one and points at the origin.
  `GAPS_ASSERT(a_nf_shape, (out_valid && !out_found) |-> (out_last && out_path_x == '0 && out_path_y == '0), "bad not-found result")

endmodule
